// ===== rtl/multi_pattern_kmp_matcher_macros.svh =====
// ----------------------------------------------------------------------------
// multi_pattern_kmp_matcher_macros
// Assertion macros for the multi-pattern matcher.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_KMP_MATCHER_MACROS_SVH
`define MULTI_PATTERN_KMP_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define KMP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define KMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KMP_ASSERT_IMP(label, ante, cons, msg)
`define KMP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Types, codes and helpers shared by the multi-pattern matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;
  localparam int NUM_PATTERNS_DEF    = 8;
  localparam int MAX_PATTERN_LEN_DEF = 32;
  localparam int RESULT_LIMIT        = 8;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_PATTERN = 2'd1;
  localparam logic [1:0] CMD_TEXT    = 2'd2;
  localparam logic [1:0] CMD_SPARE   = 2'd3;

  localparam logic [1:0] KIND_MATCH  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_in;
    logic       word_end;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  pattern_index;
    logic [15:0] match_row;
    logic [15:0] match_col;
    logic        last_of_run;
  } out_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UA && c <= CH_UZ) r = c + (CH_LA - CH_UA);
    return r;
  endfunction
endpackage

// ===== rtl/kmp_ram.sv =====
// ----------------------------------------------------------------------------
// kmp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/multi_pattern_kmp_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_kmp_matcher
// Pattern loading with KMP failure-table build, then case-folded text
// matching against every stored pattern through one shared compare unit.
// Pattern chars are stored in idle; a word end builds a valid pattern's failure
// table with failure hops; a text byte is checked against each stored pattern
// in turn with failure hops, and each match queues a result word. Line end and
// clear act in idle. One input word at a time; output stalls hold the block.
// Reset: counters to zero, row and column to 1; RAM contents undefined.
// ----------------------------------------------------------------------------
`include "multi_pattern_kmp_matcher_macros.svh"

module multi_pattern_kmp_matcher import kmp_pkg::*; #(
  parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);
  localparam int CDEPTH = NUM_PATTERNS * MAX_PATTERN_LEN;
  localparam int FDEPTH = NUM_PATTERNS * (MAX_PATTERN_LEN + 1);
  localparam int CA = $clog2(CDEPTH);
  localparam int FA = $clog2(FDEPTH);
  localparam int CW = $clog2(NUM_PATTERNS + 1);
  localparam int IW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int PW = $clog2(MAX_PATTERN_LEN + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LEND = 4'd1;
  localparam logic [3:0] S_B0   = 4'd2;
  localparam logic [3:0] S_B1   = 4'd3;
  localparam logic [3:0] S_B2   = 4'd4;
  localparam logic [3:0] S_B3   = 4'd5;
  localparam logic [3:0] S_B4   = 4'd6;
  localparam logic [3:0] S_B5   = 4'd7;
  localparam logic [3:0] S_B6   = 4'd8;
  localparam logic [3:0] S_BEND = 4'd9;
  localparam logic [3:0] S_T0   = 4'd10;
  localparam logic [3:0] S_T1   = 4'd11;
  localparam logic [3:0] S_T2   = 4'd12;
  localparam logic [3:0] S_T3   = 4'd13;
  localparam logic [3:0] S_T4   = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0]           state;
  logic [CW-1:0]        count;
  logic [PW-1:0]        pos;
  logic                 inv;
  logic [PW-1:0]        lens [NUM_PATTERNS];
  logic [PW-1:0]        ptrs [NUM_PATTERNS];
  logic [15:0]          row;
  logic [15:0]          col;
  logic [7:0]           c;
  logic [CW-1:0]        i;
  logic signed [PW:0]   p;
  logic signed [PW:0]   t;
  logic [PW-1:0]        j;
  logic [PW-1:0]        blen;
  logic [7:0]           cj;
  logic [3:0]           n_res;
  logic                 pend_valid;
  out_t                 pend;

  logic                 c_we;
  logic [CA-1:0]        c_waddr;
  logic [7:0]           c_wdata;
  logic [CA-1:0]        c_raddr;
  logic [7:0]           c_rdata;
  logic                 f_we;
  logic [FA-1:0]        f_waddr;
  logic [PW:0]          f_wdata;
  logic [FA-1:0]        f_raddr;
  logic [PW:0]          f_rdata;

  logic                 out_free;
  logic                 out_load;
  logic                 can_push;
  logic [IW-1:0]        i_idx;
  logic [IW-1:0]        cnt_idx;
  logic [PW-1:0]        cur_len;
  logic [CA-1:0]        cbase;
  logic [FA-1:0]        fbase;
  logic                 full;
  logic [7:0]           in_fold;
  logic                 bad_char;
  logic signed [PW:0]   p_inc;
  logic signed [PW:0]   t_inc;
  logic [PW:0]          j_inc;
  logic [16:0]          col17;
  logic [15:0]          mcol;
  logic [CW+2:0]        i_ext;
  logic [CW+2:0]        cnt_ext;

  kmp_ram #(.WIDTH(8), .DEPTH(CDEPTH)) u_chars (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  kmp_ram #(.WIDTH(PW + 1), .DEPTH(FDEPTH)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign can_push = !pend_valid || out_free;
  assign i_idx    = i[IW-1:0];
  assign cnt_idx  = count[IW-1:0];
  assign cur_len  = lens[i_idx];
  assign cbase    = CA'(CA'(i) * CA'(MAX_PATTERN_LEN));
  assign fbase    = FA'(FA'(i) * FA'(MAX_PATTERN_LEN + 1));
  assign full     = (count >= CW'(NUM_PATTERNS));
  assign in_fold  = fold(in_data.char_in);
  assign bad_char = !((in_fold >= CH_LA && in_fold <= CH_LZ) || in_fold == CH_HYPHEN);
  assign p_inc    = p + (PW+1)'(1);
  assign t_inc    = t + (PW+1)'(1);
  assign j_inc    = {1'b0, j} + (PW+1)'(1);
  assign col17    = {1'b0, col} + 17'd1;
  assign mcol     = (col17 > 17'(cur_len)) ? 16'(col17 - 17'(cur_len)) : 16'd1;
  assign i_ext    = (CW+3)'(i);
  assign cnt_ext  = (CW+3)'(count);

  always_comb begin
    c_we    = in_valid && !in_stall && in_data.command == CMD_PATTERN &&
              pos < PW'(MAX_PATTERN_LEN) && !full;
    c_waddr = CA'(CA'(count) * CA'(MAX_PATTERN_LEN) + CA'(pos));
    c_wdata = in_fold;
    c_raddr = cbase;
    f_we    = 1'b0;
    f_waddr = fbase;
    f_wdata = '1;
    f_raddr = fbase;
    unique case (state)
      S_B0: begin
        f_we = 1'b1;
      end
      S_B2, S_B5: begin
        c_raddr = CA'(cbase + CA'(t[PW-1:0]));
        f_raddr = FA'(fbase + FA'(t[PW-1:0]));
      end
      S_B4: begin
        if (j_inc < (PW+1)'(blen)) begin
          c_raddr = CA'(cbase + CA'(j_inc));
        end else begin
          f_we    = 1'b1;
          f_waddr = FA'(fbase + FA'(j_inc));
          f_wdata = t_inc;
        end
      end
      S_B6: begin
        f_we    = 1'b1;
        f_waddr = FA'(fbase + FA'(j));
        f_wdata = (cj == c_rdata) ? f_rdata : t;
      end
      S_T1: begin
        c_raddr = CA'(cbase + CA'(p[PW-1:0]));
        f_raddr = FA'(fbase + FA'(p[PW-1:0]));
      end
      S_T3: begin
        f_raddr = FA'(fbase + FA'(cur_len));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (state)
      S_LEND: out_load = (inv || full) && can_push && pend_valid;
      S_BEND: out_load = can_push && pend_valid;
      S_T3: out_load = (p_inc == $signed({1'b0, cur_len})) &&
                       (n_res < 4'(RESULT_LIMIT)) && can_push && pend_valid;
      S_DONE: out_load = pend_valid && out_free;
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data <= '{pend.kind, pend.pattern_index, pend.match_row, pend.match_col,
                    state == S_DONE};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pos        <= '0;
      inv        <= 1'b0;
      row        <= 16'd1;
      col        <= 16'd1;
      n_res      <= '0;
      pend_valid <= 1'b0;
      for (int k = 0; k < NUM_PATTERNS; k++) begin
        lens[k] <= '0;
        ptrs[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            priority case (in_data.command)
              CMD_CLEAR: begin
                count <= '0;
                pos   <= '0;
                inv   <= 1'b0;
                row   <= 16'd1;
                col   <= 16'd1;
                for (int k = 0; k < NUM_PATTERNS; k++) begin
                  lens[k] <= '0;
                  ptrs[k] <= '0;
                end
              end
              CMD_PATTERN: begin
                inv <= inv || bad_char || pos >= PW'(MAX_PATTERN_LEN);
                if (pos < PW'(MAX_PATTERN_LEN)) pos <= pos + PW'(1);
                if (in_data.word_end) state <= S_LEND;
              end
              CMD_TEXT: begin
                if (in_data.char_in == CH_LF || in_data.char_in == CH_CR) begin
                  if (row != 16'hFFFF) row <= row + 16'd1;
                  col <= 16'd1;
                  for (int k = 0; k < NUM_PATTERNS; k++) ptrs[k] <= '0;
                end else begin
                  c     <= in_fold;
                  i     <= '0;
                  n_res <= '0;
                  state <= S_T0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_LEND: begin
          if (inv || full) begin
            if (can_push) begin
              pend       <= '{KIND_REJECT, cnt_ext[2:0], 16'd0, 16'd0, 1'b0};
              pend_valid <= 1'b1;
              pos        <= '0;
              inv        <= 1'b0;
              state      <= S_DONE;
            end
          end else begin
            i             <= count;
            blen          <= pos;
            lens[cnt_idx] <= pos;
            ptrs[cnt_idx] <= '0;
            state         <= S_B0;
          end
        end
        S_B0: begin
          t     <= '1;
          j     <= '0;
          state <= S_B1;
        end
        S_B1: begin
          cj    <= c_rdata;
          state <= S_B2;
        end
        S_B2: begin
          state <= t[PW] ? S_B4 : S_B3;
        end
        S_B3: begin
          if (cj != c_rdata) begin
            t     <= f_rdata;
            state <= S_B2;
          end else begin
            state <= S_B4;
          end
        end
        S_B4: begin
          t     <= t_inc;
          j     <= j_inc[PW-1:0];
          state <= (j_inc < (PW+1)'(blen)) ? S_B5 : S_BEND;
        end
        S_B5: begin
          cj    <= c_rdata;
          state <= S_B6;
        end
        S_B6: begin
          state <= S_B2;
        end
        S_BEND: begin
          if (can_push) begin
            pend       <= '{KIND_ACCEPT, cnt_ext[2:0], 16'd0, 16'd0, 1'b0};
            pend_valid <= 1'b1;
            count      <= count + CW'(1);
            pos        <= '0;
            inv        <= 1'b0;
            state      <= S_DONE;
          end
        end
        S_T0: begin
          if (i < count) begin
            p     <= (ptrs[i_idx] >= cur_len) ? '0 : $signed({1'b0, ptrs[i_idx]});
            state <= S_T1;
          end else begin
            if (col != 16'hFFFF) col <= col + 16'd1;
            state <= S_DONE;
          end
        end
        S_T1: begin
          state <= p[PW] ? S_T3 : S_T2;
        end
        S_T2: begin
          if (c != c_rdata) begin
            p     <= f_rdata;
            state <= S_T1;
          end else begin
            state <= S_T3;
          end
        end
        S_T3: begin
          if (p_inc == $signed({1'b0, cur_len})) begin
            if (n_res >= 4'(RESULT_LIMIT)) begin
              state <= S_T4;
            end else if (can_push) begin
              pend       <= '{KIND_MATCH, i_ext[2:0], row, mcol, 1'b0};
              pend_valid <= 1'b1;
              n_res      <= n_res + 4'd1;
              state      <= S_T4;
            end
          end else begin
            ptrs[i_idx] <= p_inc[PW-1:0];
            i           <= i + CW'(1);
            state       <= S_T0;
          end
        end
        S_T4: begin
          ptrs[i_idx] <= f_rdata[PW] ? '0 : f_rdata[PW-1:0];
          i           <= i + CW'(1);
          state       <= S_T0;
        end
        S_DONE: begin
          if (pend_valid) begin
            if (out_free) begin
              pend_valid <= 1'b0;
              state      <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KMP_ASSERT_IMP(a_idle_no_pend, state == S_IDLE, !pend_valid, "pending word left in idle")
  `KMP_ASSERT_IMP(a_res_limit, 1'b1, n_res <= 4'(RESULT_LIMIT), "too many matches")
  `KMP_ASSERT_IMP(a_count_max, 1'b1, count <= CW'(NUM_PATTERNS), "pattern count overflow")
  `KMP_ASSERT_NEXT(a_done_idle, state == S_DONE && (!pend_valid || out_free), state == S_IDLE, "done stuck")
endmodule

// ===== sim/multi_pattern_kmp_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_kmp_matcher_tb
// Drives pattern words and text through the matcher. A local model predicts
// accept, reject and match words, and each output word is checked in order.
// ----------------------------------------------------------------------------
module multi_pattern_kmp_matcher_tb import kmp_pkg::*; ;

  localparam int NPAT = NUM_PATTERNS_DEF;
  localparam int MLEN = MAX_PATTERN_LEN_DEF;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  multi_pattern_kmp_matcher i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  logic [7:0] pat_chars [NPAT][MLEN];
  int         pat_next  [NPAT][MLEN+1];
  int         pat_len   [NPAT];
  int         pat_ptr   [NPAT];
  int         pat_count;
  int         load_pos;
  bit         load_bad;
  int         row_cnt;
  int         col_cnt;

  out_t expected_words[$];
  int   errors;
  int   send_idle;
  int   recv_idle;
  bit   hold_off;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
  endfunction

  task automatic clear_store();
    pat_count = 0;
    load_pos  = 0;
    load_bad  = 0;
    row_cnt   = 1;
    col_cnt   = 1;
    for (int i = 0; i < NPAT; i++) begin
      pat_len[i] = 0;
      pat_ptr[i] = 0;
    end
  endtask

  task automatic build_failure(input int s, input int n);
    int t;
    int j;
    t = -1;
    j = 0;
    pat_next[s][0] = -1;
    while (j < n) begin
      while (t >= 0 && pat_chars[s][j] != pat_chars[s][t]) t = pat_next[s][t];
      t++;
      j++;
      if (j < n && pat_chars[s][j] == pat_chars[s][t]) pat_next[s][j] = pat_next[s][t];
      else pat_next[s][j] = t;
    end
  endtask

  task automatic push_word(input logic [1:0] k, input int idx, input int r, input int c);
    out_t w;
    w.kind          = k;
    w.pattern_index = idx[2:0];
    w.match_row     = r[15:0];
    w.match_col     = c[15:0];
    w.last_of_run   = 1'b0;
    expected_words = {expected_words, w};
  endtask

  task automatic predict_word(input in_t d);
    logic [7:0] c;
    bit full;
    int n;
    int p;
    int col;
    n = 0;
    c = lower(d.char_in);
    if (d.command == CMD_CLEAR) begin
      clear_store();
    end else if (d.command == CMD_PATTERN) begin
      full = pat_count >= NPAT;
      if (!((c >= CH_LA && c <= CH_LZ) || c == CH_HYPHEN)) load_bad = 1;
      if (load_pos >= MLEN) load_bad = 1;
      else begin
        if (!full) pat_chars[pat_count][load_pos] = c;
        load_pos++;
      end
      if (d.word_end) begin
        if (load_bad || full) push_word(KIND_REJECT, pat_count, 0, 0);
        else begin
          pat_len[pat_count] = load_pos;
          pat_ptr[pat_count] = 0;
          build_failure(pat_count, load_pos);
          push_word(KIND_ACCEPT, pat_count, 0, 0);
          pat_count++;
        end
        n = 1;
        load_pos = 0;
        load_bad = 0;
      end
    end else if (d.command == CMD_TEXT) begin
      if (d.char_in == CH_LF || d.char_in == CH_CR) begin
        if (row_cnt < 65535) row_cnt++;
        col_cnt = 1;
        for (int i = 0; i < NPAT; i++) pat_ptr[i] = 0;
      end else begin
        for (int i = 0; i < pat_count && i < NPAT; i++) begin
          p = pat_ptr[i];
          if (p < 0 || p >= pat_len[i]) p = 0;
          while (p >= 0 && c != pat_chars[i][p]) p = pat_next[i][p];
          p++;
          if (p == pat_len[i]) begin
            col = (col_cnt + 1 > pat_len[i]) ? col_cnt + 1 - pat_len[i] : 1;
            if (n < RESULT_LIMIT) begin
              push_word(KIND_MATCH, i, row_cnt, col);
              n++;
            end
            p = pat_next[i][pat_len[i]];
          end
          pat_ptr[i] = p;
        end
        if (col_cnt < 65535) col_cnt++;
      end
    end
    if (n > 0) expected_words[$].last_of_run = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input out_t got, input out_t want);
    $display("mismatch %s: got %p want %p", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_data, out_data);
      end else begin
        want = expected_words.pop_front();
        if (out_data.kind != want.kind) report_mismatch("kind", out_data, want);
        if (out_data.pattern_index != want.pattern_index)
          report_mismatch("pattern_index", out_data, want);
        if (out_data.match_row != want.match_row) report_mismatch("match_row", out_data, want);
        if (out_data.match_col != want.match_col) report_mismatch("match_col", out_data, want);
        if (out_data.last_of_run != want.last_of_run)
          report_mismatch("last_of_run", out_data, want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b1;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic send_word(input logic [1:0] cmd, input logic [7:0] ch, input bit last);
    in_t d;
    d.command  = cmd;
    d.char_in  = ch;
    d.word_end = last;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      in_data  <= in_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(d);
  endtask

  task automatic send_pattern(input string s);
    for (int i = 0; i < s.len(); i++) send_word(CMD_PATTERN, s[i], i == s.len() - 1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(CMD_TEXT, s[i], 1'($urandom_range(1)));
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(9);
    if (r == 0) return CH_HYPHEN;
    if (r < 4) return CH_UA + 8'($urandom_range(2));
    return CH_LA + 8'($urandom_range(2));
  endfunction

  task automatic test_directed();
    send_pattern("abab");
    send_pattern("B-a");
    send_pattern("a1");
    send_word(CMD_PATTERN, 8'hFF, 1'b1);
    send_word(CMD_SPARE, 8'h00, 1'b0);
    send_text("ABaBab");
    send_word(CMD_TEXT, CH_CR, 1'b0);
    send_word(CMD_TEXT, CH_LF, 1'b0);
    send_text("b-ab");
    send_word(CMD_TEXT, 8'h00, 1'b0);
    send_word(CMD_CLEAR, 8'hFF, 1'b1);
  endtask

  task automatic test_long_and_full();
    for (int i = 0; i < MLEN + 2; i++) send_word(CMD_PATTERN, CH_LA, i == MLEN + 1);
    for (int i = 0; i < MLEN; i++) send_word(CMD_PATTERN, CH_LZ, i == MLEN - 1);
    for (int k = 0; k < NPAT; k++) send_word(CMD_PATTERN, CH_LZ, 1'b1);
    send_word(CMD_PATTERN, CH_UZ, 1'b1);
    send_text("zzZ");
    send_word(CMD_CLEAR, 8'h00, 1'b0);
  endtask

  task automatic test_random(input int count);
    int sent;
    int len;
    int np;
    sent = 0;
    while (sent < count) begin
      np = $urandom_range(1, NPAT);
      send_word(CMD_CLEAR, 8'($urandom), 1'($urandom_range(1)));
      for (int p = 0; p < np; p++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, MLEN + 2) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          send_word(CMD_PATTERN, ($urandom_range(19) == 0) ? 8'($urandom) : rand_letter(),
                    i == len - 1);
          sent++;
        end
      end
      for (int i = 0; i < 40; i++) begin
        case ($urandom_range(19))
          0: send_word(CMD_TEXT, $urandom_range(1) ? CH_CR : CH_LF, 1'($urandom_range(1)));
          1: send_word(CMD_TEXT, 8'($urandom), 1'($urandom_range(1)));
          2: send_word(CMD_SPARE, 8'($urandom), 1'($urandom_range(1)));
          default: send_word(CMD_TEXT, rand_letter(), 1'($urandom_range(1)));
        endcase
        sent++;
      end
    end
  endtask

  task automatic test_hold_off();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_pattern("a");
        send_pattern("A");
        for (int i = 0; i < 30; i++) send_word(CMD_TEXT, CH_LA, 1'b0);
      end
    join
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  initial begin
    errors       = 0;
    hold_off     = 1'b0;
    send_idle    = 22;
    recv_idle    = 48;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    clear_store();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_long_and_full();
    test_hold_off();
    test_random(40);
    send_idle = 48;
    recv_idle = 22;
    test_random(40);
    send_idle = 0;
    recv_idle = 0;
    test_random(40);
    send_word(CMD_CLEAR, 8'h00, 1'b0);
    send_pattern("q");
    drain();
    if (errors == 0) $display("multi_pattern_kmp_matcher verification clean");
    else $display("multi_pattern_kmp_matcher verification failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("multi_pattern_kmp_matcher verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/kmp_pkg.sv
rtl/kmp_ram.sv
rtl/multi_pattern_kmp_matcher.sv
sim/multi_pattern_kmp_matcher_tb.sv
